// File: design/ultrasonic_range_average_detect_defines.svh
// ----------------------------------------------------------------------------
// ultrasonic range average detect: assertion macros
// shared concurrent assertion forms, clocked on clk, off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_RANGE_AVERAGE_DETECT_DEFINES_SVH
`define ULTRASONIC_RANGE_AVERAGE_DETECT_DEFINES_SVH

// condition implies property in the same cycle
`define URAD_ASSERT_SAME(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("urad assertion failed");

// condition implies property in the next cycle
`define URAD_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("urad assertion failed");

`endif

// File: design/urad_pkg.sv
// ----------------------------------------------------------------------------
// urad_pkg
// types and constants of the ultrasonic range averaging block
// ----------------------------------------------------------------------------
package urad_pkg;

  localparam int EchoW   = 16;
  localparam int DistW   = 13;
  localparam int CountW  = 4;
  localparam int SumW    = 17;
  localparam int DvdW    = EchoW + 3;   // shared register: echo, distance, sum, quotient
  localparam int DvsrW   = 5;
  localparam int StepW   = 5;
  localparam int AddrW   = 4;
  localparam int DataW   = 32;
  localparam int OutDataW = 24;

  // cm per us round trip is 1/58, in 1/16 cm that is 8/29;
  // floor(w*8/29) equals floor(w*DIST_RECIP / 2^21) for every 16-bit w
  localparam int RecipW     = 20;
  localparam int RecipShift = 21;
  localparam int ProdW      = EchoW + RecipW;
  localparam int QuotW      = ProdW - RecipShift;
  localparam logic [RecipW-1:0] DIST_RECIP = 20'd578525;
  localparam logic [StepW-1:0]  DIV_STEPS  = 5'(DvdW);

  localparam logic [CountW-1:0] SPW_RESET = 4'd5;
  localparam logic [DistW-1:0]  MIN_RESET = 13'd32;
  localparam logic [DistW-1:0]  MAX_RESET = 13'd6400;
  localparam logic [DistW-1:0]  THR_RESET = 13'd800;

  typedef enum logic [1:0] {
    REG_SPW = 2'd0,
    REG_MIN = 2'd1,
    REG_MAX = 2'd2,
    REG_THR = 2'd3
  } reg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_DIV_DIST = 5'b00010,
    ST_UPDATE   = 5'b00100,
    ST_DIV_AVG  = 5'b01000,
    ST_FINISH   = 5'b10000
  } state_t;

endpackage

// File: design/ultrasonic_range_average_detect.sv
// ----------------------------------------------------------------------------
// ultrasonic range average detect
// converts echo widths to distance, averages valid ones over a window, flags
// ----------------------------------------------------------------------------
// sequence: each request passes a load, a reciprocal-multiply distance step and
//   an update before the next request is accepted; a window-closing request
//   also runs the radix-2 divider (19 steps) and the finish, only the finish
//   when no sample was valid, and out_tready can hold the finish
// a new request is taken only once the last one is through, in_tready is idle-only
// reset: synchronous active-low rst_n, state and config registers are reset
module ultrasonic_range_average_detect (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [urad_pkg::EchoW-1:0]  in_tdata,   // [15:0] echo_width
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // [12:0] average_distance, [13] no_valid_sample, [14] detected,
  // [18:15] valid_count, [23:19] zero
  output logic [urad_pkg::OutDataW-1:0] out_tdata,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [urad_pkg::AddrW-1:0]  cfg_paddr,
  input  logic [urad_pkg::DataW-1:0]  cfg_pwdata,
  output logic [urad_pkg::DataW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);
  import urad_pkg::*;

`include "ultrasonic_range_average_detect_defines.svh"

  state_t              state_r, state_nxt;
  logic [CountW-1:0]   spw_r, min_unused_n;
  logic [DistW-1:0]    min_r, max_r, thr_r;
  logic [CountW-1:0]   win_pos_r, win_pos_nxt;
  logic [CountW-1:0]   good_r, good_nxt;
  logic [SumW-1:0]     sum_r, sum_nxt;
  logic [DvdW-1:0]     dvd_r, dvd_nxt;
  logic [DvsrW-1:0]    dvsr_r, dvsr_nxt;
  logic [DvsrW-1:0]    rem_r, rem_nxt;
  logic [StepW-1:0]    step_r, step_nxt;
  logic                zero_r, zero_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DistW-1:0]    out_avg_r, out_avg_nxt;
  logic                out_none_r, out_none_nxt;
  logic                out_det_r, out_det_nxt;
  logic [CountW-1:0]   out_cnt_r, out_cnt_nxt;

  logic                cfg_wr;
  reg_idx_t            cfg_idx;
  logic [DvsrW:0]      rem_sh;
  logic                rem_ge;
  logic [ProdW-1:0]    dist_prod;
  logic                dist_ok;
  logic [CountW-1:0]   pos_inc, win_len, good_inc;
  logic [SumW-1:0]     sum_inc;
  logic                win_close;
  logic                out_free;

  assign min_unused_n = spw_r;  // window length read in update step

  // ---------------- configuration ----------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[AddrW-1:2]);

  always_comb begin
    case (cfg_idx)
      REG_SPW: cfg_prdata = {{(DataW-CountW){1'b0}}, spw_r};
      REG_MIN: cfg_prdata = {{(DataW-DistW){1'b0}}, min_r};
      REG_MAX: cfg_prdata = {{(DataW-DistW){1'b0}}, max_r};
      REG_THR: cfg_prdata = {{(DataW-DistW){1'b0}}, thr_r};
      default: cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spw_r <= SPW_RESET;
      min_r <= MIN_RESET;
      max_r <= MAX_RESET;
      thr_r <= THR_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SPW: spw_r <= cfg_pwdata[CountW-1:0];
        REG_MIN: min_r <= cfg_pwdata[DistW-1:0];
        REG_MAX: max_r <= cfg_pwdata[DistW-1:0];
        REG_THR: thr_r <= cfg_pwdata[DistW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- divider step ----------------
  assign rem_sh = {rem_r, dvd_r[DvdW-1]};
  assign rem_ge = rem_sh >= {1'b0, dvsr_r};

  // distance by reciprocal multiply of the registered echo width
  assign dist_prod = ProdW'(dvd_r[EchoW-1:0]) * ProdW'(DIST_RECIP);

  // ---------------- window update terms ----------------
  assign dist_ok  = !zero_r && (dvd_r >= {{(DvdW-DistW){1'b0}}, min_r})
                            && (dvd_r <= {{(DvdW-DistW){1'b0}}, max_r});
  assign sum_inc  = sum_r + dvd_r[SumW-1:0];
  assign good_inc = good_r + 4'd1;
  assign pos_inc  = win_pos_r + 4'd1;
  assign win_len  = (min_unused_n == '0) ? 4'd1 : min_unused_n;
  assign win_close = !((pos_inc < win_len) && (pos_inc != '0));
  assign out_free = !out_valid_r || out_tready;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    win_pos_nxt   = win_pos_r;
    good_nxt      = good_r;
    sum_nxt       = sum_r;
    dvd_nxt       = dvd_r;
    dvsr_nxt      = dvsr_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    zero_nxt      = zero_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_avg_nxt   = out_avg_r;
    out_none_nxt  = out_none_r;
    out_det_nxt   = out_det_r;
    out_cnt_nxt   = out_cnt_r;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          dvd_nxt   = {{(DvdW-EchoW){1'b0}}, in_tdata};
          zero_nxt  = (in_tdata == '0);
          state_nxt = ST_DIV_DIST;
        end
      end
      ST_DIV_DIST: begin
        dvd_nxt   = {{(DvdW-QuotW){1'b0}}, dist_prod[ProdW-1:RecipShift]};
        state_nxt = ST_UPDATE;
      end
      ST_DIV_AVG: begin
        rem_nxt  = rem_ge ? 5'(rem_sh - {1'b0, dvsr_r}) : rem_sh[DvsrW-1:0];
        dvd_nxt  = {dvd_r[DvdW-2:0], rem_ge};
        step_nxt = step_r - 5'd1;
        if (step_r == 5'd1) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_UPDATE: begin
        // dvd_r holds the distance quotient here
        if (dist_ok) begin
          sum_nxt  = sum_inc;
          good_nxt = good_inc;
        end
        win_pos_nxt = pos_inc;
        if (!win_close) begin
          state_nxt = ST_IDLE;
        end else if (good_nxt == '0) begin
          dvd_nxt   = '0;
          state_nxt = ST_FINISH;
        end else begin
          dvd_nxt   = {{(DvdW-SumW){1'b0}}, sum_nxt};
          dvsr_nxt  = {1'b0, good_nxt};
          rem_nxt   = '0;
          step_nxt  = DIV_STEPS;
          state_nxt = ST_DIV_AVG;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_avg_nxt   = dvd_r[DistW-1:0];
          out_none_nxt  = (good_r == '0);
          out_det_nxt   = (good_r != '0) && (dvd_r[DistW-1:0] != '0)
                          && (dvd_r[DistW-1:0] <= thr_r);
          out_cnt_nxt   = good_r;
          win_pos_nxt   = '0;
          good_nxt      = '0;
          sum_nxt       = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      win_pos_r   <= '0;
      good_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      win_pos_r   <= win_pos_nxt;
      good_r      <= good_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r      <= dvd_nxt;
    dvsr_r     <= dvsr_nxt;
    rem_r      <= rem_nxt;
    zero_r     <= zero_nxt;
    out_avg_r  <= out_avg_nxt;
    out_none_r <= out_none_nxt;
    out_det_r  <= out_det_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OutDataW-DistW-2-CountW){1'b0}},
                       out_cnt_r, out_det_r, out_none_r, out_avg_r};

  // ---------------- assertions ----------------
  `URAD_ASSERT_NEXT(a_accept_starts_div, in_tvalid && in_tready, state_r == ST_DIV_DIST)
  `URAD_ASSERT_NEXT(a_finish_clears, (state_r == ST_FINISH) && out_free,
                    out_valid_r && (win_pos_r == '0) && (good_r == '0) && (sum_r == '0))
  `URAD_ASSERT_SAME(a_good_le_pos, state_r == ST_IDLE, good_r <= win_pos_r)
  `URAD_ASSERT_SAME(a_rem_below_dvsr, state_r == ST_DIV_AVG,
                    (rem_r < dvsr_r) && (step_r != '0))

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: ultrasonic range average detect testbench
// streams echo widths into the block, predicts each window average with a
// local model of the converter and window accumulator, and checks the average,
// no_valid_sample, detected and valid_count; settings change between drained phases
// ----------------------------------------------------------------------------
module tb_top;
  import urad_pkg::*;

  localparam int SETTLE_CYCLES = 60;    // covers a window-closing request and the finish
  localparam int STALL_LIMIT   = 4000;
  localparam int BLOCK_ITEMS   = 50;
  localparam int BLOCKS        = 11;

  typedef struct packed {
    logic [DistW-1:0]  avg;
    logic              none;
    logic              det;
    logic [CountW-1:0] count;
  } window_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [EchoW-1:0]     in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OutDataW-1:0]  out_tdata;
  logic                 cfg_psel = 1'b0;
  logic                 cfg_penable = 1'b0;
  logic                 cfg_pwrite = 1'b0;
  logic [AddrW-1:0]     cfg_paddr = '0;
  logic [DataW-1:0]     cfg_pwdata = '0;
  logic [DataW-1:0]     cfg_prdata;
  logic                 cfg_pready;

  // predictor copy of the registers and the running window
  logic [CountW-1:0] spw_cfg = SPW_RESET;
  logic [DistW-1:0]  min_cfg = MIN_RESET;
  logic [DistW-1:0]  max_cfg = MAX_RESET;
  logic [DistW-1:0]  thr_cfg = THR_RESET;
  logic [CountW-1:0] win_pos = '0;
  logic [CountW-1:0] good_cnt = '0;
  logic [SumW-1:0]   dist_sum = '0;

  logic [EchoW-1:0]  echo_queue [$];
  window_result_t    expected_windows [$];
  window_result_t    monitor_want;

  int send_idle_pct = 17;
  int recv_idle_pct = 59;
  int err_count = 0;
  int echoes_taken = 0;
  int windows_seen = 0;
  int settings_used = 1;
  int idle_cycles = 0;

  ultrasonic_range_average_detect dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),      // [15:0] echo_width
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    // [12:0] average_distance, [13] no_valid_sample, [14] detected,
    // [18:15] valid_count, [23:19] zero
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    err_count++;
  endtask

  // converts one echo, adds it to the window and queues the average at window end
  task automatic accumulate_echo(logic [EchoW-1:0] width);
    logic [14:0]    dist_val;
    int             len;
    window_result_t res;
    len = (spw_cfg == 0) ? 1 : int'(spw_cfg);
    if (width != 0) begin
      dist_val = 15'((20'(width) * 20'd8) / 20'd29);
      if (dist_val >= min_cfg && dist_val <= max_cfg) begin
        dist_sum = dist_sum + SumW'(dist_val);
        good_cnt = good_cnt + 1'b1;
      end
    end
    win_pos = win_pos + 1'b1;
    if (int'(win_pos) < len && win_pos != 0) return;
    res.none  = (good_cnt == 0);
    res.avg   = res.none ? '0 : DistW'(dist_sum / good_cnt);
    res.det   = !res.none && res.avg > 0 && res.avg <= thr_cfg;
    res.count = good_cnt;
    expected_windows.push_back(res);
    win_pos  = '0;
    good_cnt = '0;
    dist_sum = '0;
  endtask

  // mostly echoes that land near the accepted range, some timeouts and noise
  function automatic logic [EchoW-1:0] pick_echo();
    int unsigned roll, lo, hi, target, w;
    roll = $urandom_range(99);
    if (roll < 8) return '0;
    if (roll < 18) return EchoW'($urandom);
    lo = (min_cfg > 24) ? min_cfg - 24 : 0;
    hi = max_cfg + 24;
    if (lo > hi) begin
      target = lo;
      lo = hi;
      hi = target;
    end
    target = $urandom_range(hi, lo);
    w = (target * 29) / 8 + $urandom_range(3);
    return (w > 65535) ? 16'hFFFF : EchoW'(w);
  endfunction

  // driver: one request per handshake, random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        accumulate_echo(in_tdata);
        echoes_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (echo_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= echo_queue.pop_front();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: random backpressure, field-by-field compare
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_tvalid && out_tready) begin
        windows_seen++;
        if (expected_windows.size() == 0) begin
          report_mismatch("result with no window pending", int'(out_tdata), 0);
        end else begin
          monitor_want = expected_windows.pop_front();
          if (out_tdata[12:0] != monitor_want.avg)
            report_mismatch("average_distance", out_tdata[12:0], monitor_want.avg);
          if (out_tdata[13] != monitor_want.none)
            report_mismatch("no_valid_sample", out_tdata[13], monitor_want.none);
          if (out_tdata[14] != monitor_want.det)
            report_mismatch("detected", out_tdata[14], monitor_want.det);
          if (out_tdata[18:15] != monitor_want.count)
            report_mismatch("valid_count", out_tdata[18:15], monitor_want.count);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("FAIL ultrasonic_range_average_detect");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // upper bits of the write word carry junk half the time
  task automatic write_reg(reg_idx_t idx, int unsigned value, int unsigned mask);
    logic [DataW-1:0] word;
    word = (value & mask) | (($urandom_range(1) ? $urandom : 0) & ~mask);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= word;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_SPW: spw_cfg = word[CountW-1:0];
      REG_MIN: min_cfg = word[DistW-1:0];
      REG_MAX: max_cfg = word[DistW-1:0];
      REG_THR: thr_cfg = word[DistW-1:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(int unsigned spw, int unsigned mn, int unsigned mx,
                               int unsigned thr);
    write_reg(REG_SPW, spw, 32'hF);
    write_reg(REG_MIN, mn, 32'h1FFF);
    write_reg(REG_MAX, mx, 32'h1FFF);
    write_reg(REG_THR, thr, 32'h1FFF);
    settings_used++;
  endtask

  // sender holds off until every pending window result is back and the block is idle
  task automatic wait_drained();
    do @(negedge clk);
    while (echo_queue.size() != 0 || in_tvalid || expected_windows.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int unsigned a, b;
    logic [EchoW-1:0] opening [15];
    // range edges, timeout, empty window, detection at the threshold
    opening = '{16'd0, 16'd1, 16'hFFFF, 16'd116, 16'd23200,
                16'd0, 16'd0, 16'd0, 16'd0, 16'd0,
                16'd2900, 16'd2900, 16'd2904, 16'd23204, 16'd3};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (opening[i]) echo_queue.push_back(opening[i]);
    wait_drained();
    // zero window length acts as one; timeout stays invalid with min at zero
    load_settings(0, 0, 6400, 800);
    echo_queue.push_back(16'd0);
    echo_queue.push_back(16'd1);
    echo_queue.push_back(16'd4);
    wait_drained();
    // shorten the window after it has run past the new length
    load_settings(10, 32, 6400, 800);
    repeat (7) echo_queue.push_back(pick_echo());
    wait_drained();
    load_settings(3, 32, 6400, 800);
    echo_queue.push_back(16'd2900);
    wait_drained();

    for (int blk = 0; blk < BLOCKS; blk++) begin
      if (blk == 4) begin
        send_idle_pct = 59;
        recv_idle_pct = 17;
      end else if (blk == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      a = $urandom_range(6400);
      b = $urandom_range(6400);
      case (blk)
        0: load_settings(15, 0, 8191, 8191);
        1: load_settings(1, 6400, 6400, 6400);
        2: load_settings(4, 100, 3000, 0);
        4: load_settings(15, 5000, 200, 3000);   // min above max, nothing valid
        5: load_settings(0, 0, 6400, 800);
        default: load_settings($urandom_range(15), (a < b) ? a : b, (a < b) ? b : a,
                               $urandom_range(6400));
      endcase
      repeat (BLOCK_ITEMS) echo_queue.push_back(pick_echo());
      wait_drained();
    end

    $display("run covered %0d echoes, %0d window results, %0d register settings",
             echoes_taken, windows_seen, settings_used);
    $display("mismatches: %0d", err_count);
    if (err_count == 0) begin
      $display("PASS ultrasonic_range_average_detect");
    end else begin
      $display("FAIL ultrasonic_range_average_detect");
    end
    $finish;
  end

endmodule
